// ===== src/rut_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rut_pkg
// Types and codes shared by the resource use tracker modules.
// ----------------------------------------------------------------------------
package rut_pkg;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [5:0]  slot;
    logic [31:0] offset;
    logic [31:0] length;
  } item_t;

  typedef struct packed {
    logic       answer;
    logic       destroy_now;
    logic [2:0] error;
  } result_t;

  localparam logic [3:0] CMD_BIND        = 4'd0;
  localparam logic [3:0] CMD_USE         = 4'd1;
  localparam logic [3:0] CMD_DONE        = 4'd2;
  localparam logic [3:0] CMD_UNBIND      = 4'd3;
  localparam logic [3:0] CMD_DESTROY     = 4'd4;
  localparam logic [3:0] CMD_SLOT_BIND   = 4'd5;
  localparam logic [3:0] CMD_SLOT_USE    = 4'd6;
  localparam logic [3:0] CMD_SLOT_DONE   = 4'd7;
  localparam logic [3:0] CMD_SLOT_UNBIND = 4'd8;
  localparam logic [3:0] CMD_SLOT_BOUND  = 4'd9;
  localparam logic [3:0] CMD_SLOT_BUSY   = 4'd10;
  localparam logic [3:0] CMD_RANGE_BOUND = 4'd11;
  localparam logic [3:0] CMD_RANGE_BUSY  = 4'd12;

  localparam logic [2:0] ERR_OK            = 3'd0;
  localparam logic [2:0] ERR_UNDERFLOW     = 3'd1;
  localparam logic [2:0] ERR_SLOT_RANGE    = 3'd2;
  localparam logic [2:0] ERR_DESTROY_AGAIN = 3'd3;
  localparam logic [2:0] ERR_BIND_DESTROY  = 3'd4;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_SLOT_SIZE  = 1'b1;

  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_SLOT   = 2'd1;
  localparam logic [1:0] KIND_RANGE  = 2'd2;

  localparam int unsigned DIV_BITS = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic simple;
    logic slot_rd;
    logic slot_wb;
    logic div_start;
    logic div_step;
    logic scan_rd;
    logic scan_chk;
    logic scan_done;
    logic scan_ans;
    logic clr;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       div_done;
    logic       scan_end;
    logic       hit;
    logic       clr_req;
    logic       clr_last;
    logic       out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== src/rut_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rut_datapath
// Counters, slot memory, dual divider, range scan, config regs, result reg.
// ----------------------------------------------------------------------------
module rut_datapath #(
  parameter int unsigned MAX_SLOTS  = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rut_pkg::item_t  in_data_i,
  input  wire rut_pkg::dp_cmd_t cmd_i,
  output rut_pkg::dp_sts_t     sts_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output rut_pkg::result_t     out_data_o
);
  import rut_pkg::*;

  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CB = COUNT_BITS;

  item_t           item_q;
  logic [CB-1:0]   wb_q, wb_d, wu_q, wu_d;
  logic            destroy_q, destroy_d;
  logic [6:0]      slot_count_q;
  logic [31:0]     slot_size_q;
  logic [DIV_BITS:0]   rem_a_q, rem_b_q, rem_a_d, rem_b_d;
  logic [DIV_BITS-1:0] quo_a_q, quo_b_q, quo_a_d, quo_b_d;
  logic [4:0]      div_cnt_q;
  logic [SW-1:0]   clr_cnt_q;
  logic [2*CB-1:0] mem [MAX_SLOTS];
  logic [2*CB-1:0] rdata_q;
  logic            out_valid_q;
  result_t         out_q;

  logic [CW-1:0]   eff;
  logic            on, slot_bad, cfg_wr;
  logic [1:0]      kind;
  result_t         res_simple, res_slot;
  logic [CB-1:0]   sb_n, su_n, sb, su;
  logic            slot_we;
  logic [SW-1:0]   maddr;
  logic            mwe;
  logic [2*CB-1:0] mwdata;
  logic [32:0]     last_sum;
  logic [31:0]     last_byte;

  function automatic logic [CB-1:0] inc_sat(input logic [CB-1:0] v);
    return (v == {CB{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign eff = ({25'b0, slot_count_q} > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                       : CW'(slot_count_q);
  assign on       = eff > CW'(1);
  assign slot_bad = 32'(item_q.slot) >= 32'(eff);
  assign cfg_wr   = psel & penable & pwrite;

  // decode of the held item
  always_comb begin
    kind = KIND_SIMPLE;
    if (item_q.cmd inside {[CMD_SLOT_BIND:CMD_SLOT_BUSY]}) begin
      if (on && !slot_bad) kind = KIND_SLOT;
    end else if (item_q.cmd inside {CMD_RANGE_BOUND, CMD_RANGE_BUSY}) begin
      if (on && item_q.length != '0) kind = KIND_RANGE;
    end
  end

  assign sts_o.kind = kind;

  // whole-buffer commands and fallbacks
  always_comb begin
    res_simple = '0;
    wb_d = wb_q;
    wu_d = wu_q;
    destroy_d = destroy_q;
    case (item_q.cmd)
      CMD_BIND: begin
        if (destroy_q) res_simple.error = ERR_BIND_DESTROY;
        else wb_d = inc_sat(wb_q);
      end
      CMD_USE: wu_d = inc_sat(wu_q);
      CMD_DONE: begin
        if (wu_q == '0 || wb_q == '0) res_simple.error = ERR_UNDERFLOW;
        else begin
          wu_d = wu_q - 1'b1;
          wb_d = wb_q - 1'b1;
          res_simple.destroy_now = (wb_q == CB'(1)) && destroy_q;
        end
      end
      CMD_UNBIND: begin
        if (wb_q == '0) res_simple.error = ERR_UNDERFLOW;
        else begin
          wb_d = wb_q - 1'b1;
          res_simple.destroy_now = (wb_q == CB'(1)) && destroy_q;
        end
      end
      CMD_DESTROY: begin
        if (destroy_q) res_simple.error = ERR_DESTROY_AGAIN;
        else begin
          destroy_d = 1'b1;
          res_simple.destroy_now = (wb_q == '0);
        end
      end
      CMD_SLOT_BIND, CMD_SLOT_USE, CMD_SLOT_DONE, CMD_SLOT_UNBIND: begin
        if (on) res_simple.error = ERR_SLOT_RANGE;
      end
      CMD_SLOT_BOUND: begin
        if (on) res_simple.error = ERR_SLOT_RANGE;
        else res_simple.answer = (wb_q != '0);
      end
      CMD_SLOT_BUSY: begin
        if (on) res_simple.error = ERR_SLOT_RANGE;
        else res_simple.answer = (wu_q != '0);
      end
      CMD_RANGE_BOUND: res_simple.answer = (item_q.length != '0) && (wb_q != '0);
      CMD_RANGE_BUSY:  res_simple.answer = (item_q.length != '0) && (wu_q != '0);
      default: ;
    endcase
  end

  // slot read-modify-write
  assign sb = rdata_q[2*CB-1:CB];
  assign su = rdata_q[CB-1:0];
  always_comb begin
    res_slot = '0;
    sb_n = sb;
    su_n = su;
    slot_we = 1'b0;
    case (item_q.cmd)
      CMD_SLOT_BIND: begin
        sb_n = inc_sat(sb);
        slot_we = 1'b1;
      end
      CMD_SLOT_USE: begin
        su_n = inc_sat(su);
        slot_we = 1'b1;
      end
      CMD_SLOT_DONE: begin
        if (su == '0 || sb == '0) res_slot.error = ERR_UNDERFLOW;
        else begin
          sb_n = sb - 1'b1;
          su_n = su - 1'b1;
          slot_we = 1'b1;
        end
      end
      CMD_SLOT_UNBIND: begin
        if (sb == '0) res_slot.error = ERR_UNDERFLOW;
        else begin
          sb_n = sb - 1'b1;
          slot_we = 1'b1;
        end
      end
      CMD_SLOT_BOUND: res_slot.answer = (sb != '0);
      CMD_SLOT_BUSY:  res_slot.answer = (su != '0);
      default: ;
    endcase
  end

  // last byte of the range, saturated
  assign last_sum  = {1'b0, item_q.offset} + {1'b0, item_q.length} - 33'd1;
  assign last_byte = last_sum[32] ? 32'hFFFF_FFFF : last_sum[31:0];

  // two restoring dividers sharing slot_size; size zero gives quotient zero
  always_comb begin
    logic [DIV_BITS:0] sh_a, sh_b;
    logic              ge_a, ge_b;
    sh_a = {rem_a_q[DIV_BITS-1:0], quo_a_q[DIV_BITS-1]};
    sh_b = {rem_b_q[DIV_BITS-1:0], quo_b_q[DIV_BITS-1]};
    ge_a = (slot_size_q != '0) && (sh_a >= {1'b0, slot_size_q});
    ge_b = (slot_size_q != '0) && (sh_b >= {1'b0, slot_size_q});
    rem_a_d = ge_a ? sh_a - {1'b0, slot_size_q} : sh_a;
    rem_b_d = ge_b ? sh_b - {1'b0, slot_size_q} : sh_b;
    quo_a_d = {quo_a_q[DIV_BITS-2:0], ge_a};
    quo_b_d = {quo_b_q[DIV_BITS-2:0], ge_b};
  end

  // quo_a doubles as the scan pointer once divided, quo_b as the last slot
  assign sts_o.div_done = (div_cnt_q == 5'(DIV_BITS - 1));
  assign sts_o.scan_end = (quo_a_q > quo_b_q) || (quo_a_q >= 32'(eff));
  assign sts_o.hit      = (item_q.cmd == CMD_RANGE_BOUND) ? (sb != '0) : (su != '0);
  assign sts_o.clr_req  = cfg_wr && (paddr[2] == REG_SLOT_COUNT);
  assign sts_o.clr_last = (clr_cnt_q == SW'(MAX_SLOTS - 1)) && !sts_o.clr_req;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // memory port select
  always_comb begin
    maddr = SW'(item_q.slot);
    if (cmd_i.clr) maddr = clr_cnt_q;
    else if (cmd_i.scan_rd) maddr = quo_a_q[SW-1:0];
    mwe    = cmd_i.clr || (cmd_i.slot_wb && slot_we);
    mwdata = cmd_i.clr ? '0 : {sb_n, su_n};
  end

  always_ff @(posedge clk_i) begin
    if (mwe) mem[maddr] <= mwdata;
    if (cmd_i.slot_rd || cmd_i.scan_rd) rdata_q <= mem[maddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.div_start) begin
      rem_a_q <= '0;
      rem_b_q <= '0;
      quo_a_q <= item_q.offset;
      quo_b_q <= last_byte;
    end else if (cmd_i.div_step) begin
      rem_a_q <= rem_a_d;
      rem_b_q <= rem_b_d;
      quo_a_q <= quo_a_d;
      quo_b_q <= quo_b_d;
    end else if (cmd_i.scan_chk) begin
      quo_a_q <= quo_a_q + 32'd1;
    end
    if (cmd_i.simple) out_q <= res_simple;
    else if (cmd_i.slot_wb) out_q <= res_slot;
    else if (cmd_i.scan_done) out_q <= '{answer: cmd_i.scan_ans, destroy_now: 1'b0,
                                         error: ERR_OK};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q         <= '0;
      wu_q         <= '0;
      destroy_q    <= 1'b0;
      slot_count_q <= '0;
      slot_size_q  <= '0;
      div_cnt_q    <= '0;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.simple) begin
        wb_q      <= wb_d;
        wu_q      <= wu_d;
        destroy_q <= destroy_d;
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_SLOT_COUNT) slot_count_q <= pwdata[6:0];
        else slot_size_q <= pwdata;
      end
      if (cmd_i.div_start) div_cnt_q <= '0;
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q + 5'd1;
      if (sts_o.clr_req) clr_cnt_q <= '0;
      else if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.simple || cmd_i.slot_wb || cmd_i.scan_done) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign prdata      = (paddr[2] == REG_SLOT_COUNT) ? {25'b0, slot_count_q} : slot_size_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== src/rut_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rut_ctrl
// Sequencer: clear sweep, decode, slot update, divide and range scan.
// ----------------------------------------------------------------------------
module rut_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  ready_o,
  input  wire rut_pkg::dp_sts_t sts_i,
  output rut_pkg::dp_cmd_t      cmd_o
);
  import rut_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DECODE   = 3'd2;
  localparam logic [2:0] ST_SLOT_WB  = 3'd3;
  localparam logic [2:0] ST_DIV      = 3'd4;
  localparam logic [2:0] ST_SCAN_RD  = 3'd5;
  localparam logic [2:0] ST_SCAN_CHK = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    ready_o = 1'b0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        ready_o = sts_i.out_free && !sts_i.clr_req;
        if (in_valid_i && ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.kind)
          KIND_SLOT: begin
            cmd_o.slot_rd = 1'b1;
            state_d       = ST_SLOT_WB;
          end
          KIND_RANGE: begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
          default: begin
            cmd_o.simple = 1'b1;
            state_d      = ST_IDLE;
          end
        endcase
      end
      ST_SLOT_WB: begin
        cmd_o.slot_wb = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (sts_i.scan_end) begin
          cmd_o.scan_done = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts_i.hit) begin
          cmd_o.scan_done = 1'b1;
          cmd_o.scan_ans  = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.scan_chk = 1'b1;
          state_d        = ST_SCAN_RD;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (sts_i.clr_req) state_d = ST_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  // an accepted beat is always decoded next
  a_load_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DECODE)
    else $error("accepted beat not decoded");

  // at most one result source per cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.simple, cmd_o.slot_wb, cmd_o.scan_done}))
    else $error("two result sources at once");

  // a result is only written with room in the output register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("beat accepted with output occupied");

  // no memory traffic from a command while the sweep runs
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr |-> !(cmd_o.slot_wb || cmd_o.slot_rd || cmd_o.scan_rd))
    else $error("memory access during clear sweep");

endmodule
`default_nettype wire

// ===== src/gpu_resource_use_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpu_resource_use_tracker
// Bound/use tracking of one buffer, whole and per slot, with range queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | input     | in_valid_i/in_stall_o | rut_pkg::item_t
//  out     | output    | out_valid_o/out_stall_i | rut_pkg::result_t
//  config  | input     | APB psel/penable      | slot_count @0, slot_size @4
//
// One beat at a time. Whole-buffer commands, fallbacks and slot-range errors are
// decoded and registered to the output; slot commands do a memory read, then write
// back; range queries run both dividers (one quotient bit per cycle for both ends),
// then scan the slots in between one by one, up to MAX_SLOTS of them.
// After reset and after every slot_count write a sweep over all MAX_SLOTS entries
// zeroes the slot memory; in_stall_o stays high during it.
// in_stall_o is high while a beat is in work and while the output register
// holds a result that the far side stalls.
// ----------------------------------------------------------------------------
module gpu_resource_use_tracker #(
  parameter int unsigned MAX_SLOTS  = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rut_pkg::item_t    in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rut_pkg::result_t       out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import rut_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ready;

  rut_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .ready_o    (ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rut_datapath #(
    .MAX_SLOTS  (MAX_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !ready;
  assign pready     = 1'b1;

endmodule
`default_nettype wire

// ===== sim/gpu_resource_use_tracker_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpu_resource_use_tracker_tb
// Self-checking bench: a scoreboard predicts each result beat from the
// accepted item beats and compares it field by field; the bench runs
// directed items and random phases under several slot settings and idling mixes.
// ----------------------------------------------------------------------------
module gpu_resource_use_tracker_tb;
  import rut_pkg::*;

  localparam int unsigned NSLOT   = 64;
  localparam int unsigned CMAX    = 65535;
  localparam int unsigned WD_MAX  = 20000;
  localparam int unsigned ITEM_W  = $bits(item_t);

  // Predictor with its own copy of the tracker state.
  class use_scoreboard;
    int unsigned bound_cnt, used_cnt;
    bit          kill_req;
    int unsigned sb[NSLOT];
    int unsigned su[NSLOT];
    int unsigned n_slots;
    logic [31:0] bytes_per_slot;
    result_t     pending[$];
    int          errors;

    function void clear_slots();
      foreach (sb[i]) begin
        sb[i] = 0;
        su[i] = 0;
      end
    endfunction

    function void init();
      bound_cnt = 0;
      used_cnt  = 0;
      kill_req  = 0;
      n_slots   = 0;
      bytes_per_slot = 0;
      errors = 0;
      clear_slots();
    endfunction

    function void set_reg(bit idx, logic [31:0] v);
      if (idx == REG_SLOT_COUNT) begin
        n_slots = v[6:0] > NSLOT ? NSLOT : v[6:0];
        clear_slots();
      end else begin
        bytes_per_slot = v;
      end
    endfunction

    function int unsigned map_slot(logic [31:0] off);
      if (bytes_per_slot == 0) return 0;
      return off / bytes_per_slot;
    endfunction

    function bit any_in_range(bit use_cnt, logic [31:0] off, logic [31:0] len);
      logic [32:0] last_b;
      int unsigned lo, hi;
      last_b = {1'b0, off} + {1'b0, len} - 33'd1;
      if (last_b[32]) last_b = 33'h0_FFFF_FFFF;
      lo = map_slot(off);
      hi = map_slot(last_b[31:0]);
      for (int unsigned i = lo; i <= hi && i < n_slots; i++)
        if ((use_cnt ? su[i] : sb[i]) > 0) return 1;
      return 0;
    endfunction

    // Note an accepted item beat and queue the result it causes.
    function void note_item(item_t it);
      result_t r;
      bit on;
      int unsigned s;
      r  = '0;
      on = n_slots > 1;
      s  = it.slot;
      case (it.cmd)
        CMD_BIND:
          if (kill_req) r.error = ERR_BIND_DESTROY;
          else if (bound_cnt < CMAX) bound_cnt++;
        CMD_USE: if (used_cnt < CMAX) used_cnt++;
        CMD_DONE:
          if (used_cnt == 0 || bound_cnt == 0) r.error = ERR_UNDERFLOW;
          else begin
            used_cnt--;
            bound_cnt--;
            r.destroy_now = bound_cnt == 0 && kill_req;
          end
        CMD_UNBIND:
          if (bound_cnt == 0) r.error = ERR_UNDERFLOW;
          else begin
            bound_cnt--;
            r.destroy_now = bound_cnt == 0 && kill_req;
          end
        CMD_DESTROY:
          if (kill_req) r.error = ERR_DESTROY_AGAIN;
          else begin
            kill_req = 1;
            r.destroy_now = bound_cnt == 0;
          end
        CMD_SLOT_BIND, CMD_SLOT_USE, CMD_SLOT_DONE, CMD_SLOT_UNBIND,
        CMD_SLOT_BOUND, CMD_SLOT_BUSY: begin
          if (!on) begin
            if (it.cmd == CMD_SLOT_BOUND) r.answer = bound_cnt > 0;
            else if (it.cmd == CMD_SLOT_BUSY) r.answer = used_cnt > 0;
          end else if (s >= n_slots) begin
            r.error = ERR_SLOT_RANGE;
          end else begin
            case (it.cmd)
              CMD_SLOT_BIND: if (sb[s] < CMAX) sb[s]++;
              CMD_SLOT_USE:  if (su[s] < CMAX) su[s]++;
              CMD_SLOT_DONE:
                if (su[s] == 0 || sb[s] == 0) r.error = ERR_UNDERFLOW;
                else begin
                  su[s]--;
                  sb[s]--;
                end
              CMD_SLOT_UNBIND:
                if (sb[s] == 0) r.error = ERR_UNDERFLOW;
                else sb[s]--;
              CMD_SLOT_BOUND: r.answer = sb[s] > 0;
              default:        r.answer = su[s] > 0;
            endcase
          end
        end
        CMD_RANGE_BOUND, CMD_RANGE_BUSY:
          if (it.length != 0) begin
            if (!on) r.answer = (it.cmd == CMD_RANGE_BOUND) ? bound_cnt > 0 : used_cnt > 0;
            else r.answer = any_in_range(it.cmd == CMD_RANGE_BUSY, it.offset, it.length);
          end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    // Compare a result beat with the oldest expectation.
    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.answer !== exp.answer) begin
        $error("answer: expected %0d, got %0d", exp.answer, got.answer);
        errors++;
      end
      if (got.destroy_now !== exp.destroy_now) begin
        $error("destroy_now: expected %0d, got %0d", exp.destroy_now, got.destroy_now);
        errors++;
      end
      if (got.error !== exp.error) begin
        $error("error: expected %0d, got %0d", exp.error, got.error);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  item_t       in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  result_t     out_data_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  use_scoreboard board;
  int unsigned   send_idle_pct = 0;   // chance of a gap before each beat
  int unsigned   stall_pct = 0;       // chance of stalling the result side
  int unsigned   quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  gpu_resource_use_tracker uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Result side: sample at the rising edge, restall at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < stall_pct);

  // Watchdog on cycles without any beat.
  always @(posedge clk_i)
    if (quiet_cycles >= WD_MAX) begin
      $display("** gpu_resource_use_tracker: FAILED **");
      $finish;
    end

  // APB write: setup then access cycle; pready is always high.
  task automatic write_reg(bit idx, logic [31:0] v);
    @(negedge clk_i);
    psel   <= 1;
    pwrite <= 1;
    paddr  <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, v);
    @(negedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  // One item beat; the valid is held until accepted.
  task automatic send_item(item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      in_data_i  <= item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(it);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic item_t mk(logic [3:0] c, logic [5:0] s,
                               logic [31:0] o, logic [31:0] l);
    item_t it;
    it.cmd = c;
    it.slot = s;
    it.offset = o;
    it.length = l;
    return it;
  endfunction

  // Random item, mostly valid commands aimed at configured slots.
  function automatic item_t rand_item();
    item_t it;
    int unsigned w;
    it = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
    w  = $urandom_range(99);
    if (w < 95) it.cmd = 4'($urandom_range(12));
    if (w < 60) it.cmd = 4'($urandom_range(CMD_SLOT_BIND, CMD_SLOT_BUSY));
    if (board.n_slots > 0 && $urandom_range(9) < 8)
      it.slot = 6'($urandom_range(board.n_slots - 1));
    if ($urandom_range(3) != 0) begin
      it.offset = $urandom_range(board.n_slots * 64 + 64);
      it.length = $urandom_range(300);
    end
    return it;
  endfunction

  initial begin
    board = new();
    board.init();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: whole-buffer and fallbacks, then slot extremes, ranges and destroy.
    send_item(mk(CMD_DONE, 0, 0, 0));
    send_item(mk(CMD_UNBIND, 0, 0, 0));
    send_item(mk(CMD_SLOT_BOUND, 6'h3F, 0, 0));
    send_item(mk(CMD_BIND, 0, 0, 0));
    send_item(mk(CMD_USE, 0, 0, 0));
    send_item(mk(CMD_SLOT_BIND, 6'h3F, 0, 0));
    send_item(mk(CMD_SLOT_BUSY, 0, 0, 0));
    send_item(mk(CMD_RANGE_BOUND, 0, '1, '1));
    send_item(mk(CMD_RANGE_BUSY, 0, 0, 0));
    send_item(mk(4'd15, 6'h3F, '1, '1));
    send_item(mk(CMD_DONE, 0, 0, 0));
    drain();
    write_reg(REG_SLOT_COUNT, 32'd64);
    write_reg(REG_SLOT_SIZE, 32'd16);
    send_item(mk(CMD_SLOT_BIND, 6'd63, 0, 0));
    send_item(mk(CMD_SLOT_USE, 6'd0, 0, 0));
    send_item(mk(CMD_SLOT_DONE, 6'd1, 0, 0));
    send_item(mk(CMD_SLOT_UNBIND, 6'd2, 0, 0));
    send_item(mk(CMD_RANGE_BOUND, 0, 32'd1000, 32'd100));
    send_item(mk(CMD_RANGE_BOUND, 0, 32'hFFFF_FFF0, '1));
    send_item(mk(CMD_RANGE_BUSY, 0, 0, 32'd1));
    send_item(mk(CMD_SLOT_BOUND, 6'd63, 0, 0));
    send_item(mk(CMD_BIND, 0, 0, 0));
    send_item(mk(CMD_DESTROY, 0, 0, 0));
    send_item(mk(CMD_BIND, 0, 0, 0));
    send_item(mk(CMD_DESTROY, 0, 0, 0));
    send_item(mk(CMD_UNBIND, 0, 0, 0));
    drain();

    // Random phases over slot settings and idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      case (ph)
        0: write_reg(REG_SLOT_COUNT, 32'd0);
        1: write_reg(REG_SLOT_COUNT, 32'd2);
        2: write_reg(REG_SLOT_COUNT, 32'd127);
        3: write_reg(REG_SLOT_COUNT, 32'd1);
        default: write_reg(REG_SLOT_COUNT, $urandom_range(2, 20));
      endcase
      case (ph % 3)
        0: write_reg(REG_SLOT_SIZE, 32'd0);
        1: write_reg(REG_SLOT_SIZE, $urandom_range(1, 64));
        default: write_reg(REG_SLOT_SIZE, (ph == 2) ? 32'hFFFF_FFFF : 32'd1);
      endcase
      for (int k = 0; k < 88; k++) send_item(rand_item());
      drain();
    end
    stall_pct = 0;
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("** gpu_resource_use_tracker: PASSED **");
    else
      $display("** gpu_resource_use_tracker: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/rut_pkg.sv
src/rut_datapath.sv
src/rut_ctrl.sv
src/gpu_resource_use_tracker.sv
sim/gpu_resource_use_tracker_tb.sv
